// File: rtl/core/ibfd_pkg.sv
package ibfd_pkg;

	// frame layout
	localparam int FRAME_WORDS   = 14;
	localparam int CHANNEL_COUNT = 14;
	localparam int SUM_END       = 30;
	localparam logic [7:0]  HDR0     = 8'h20;
	localparam logic [7:0]  HDR1     = 8'h40;
	localparam logic [15:0] SUM_BASE = 16'hFFFF;

	// number of channel results for a good frame, kept within the frame layout
	localparam int RESULT_COUNT = (CHANNEL_COUNT > FRAME_WORDS) ? FRAME_WORDS :
		((CHANNEL_COUNT < 1) ? 1 : CHANNEL_COUNT);
	localparam logic [3:0] LAST_INDEX = 4'(RESULT_COUNT - 1);

	// byte positions with a meaning of their own
	localparam logic [4:0] POS_HDR0 = 5'd0;
	localparam logic [4:0] POS_HDR1 = 5'd1;
	localparam logic [4:0] POS_CKS0 = 5'(SUM_END);
	localparam logic [4:0] POS_CKS1 = 5'(SUM_END + 1);

	// verdict codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_HEADER  = 2'd1;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

	typedef logic [FRAME_WORDS-1:0][15:0] words_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       start_of_frame;
	} item_t;

	typedef struct packed {
		logic [1:0]  frame_status;
		logic [3:0]  channel_index;
		logic [15:0] channel_value;
		logic        last_result;
	} result_t;

	// frame verdict handed to the result sequencer
	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		words_t     words;
	} verdict_t;

endpackage

// File: rtl/core/ibfd_burst.sv
module ibfd_burst (
	input  logic              clk,
	input  logic              arst_n,
	input  ibfd_pkg::verdict_t verdict,
	output logic              free,
	output logic              result_valid,
	input  logic              result_stall,
	output ibfd_pkg::result_t result
);

	logic                 busy_q;
	logic [3:0]           k_q;
	logic [1:0]           status_q;
	ibfd_pkg::words_t     snap_q;
	logic                 last;
	logic                 is_error;

	assign is_error = (status_q != ibfd_pkg::STATUS_OK);
	assign last     = is_error || (k_q == ibfd_pkg::LAST_INDEX);

	// take a new verdict once the final transfer of the current one goes out
	assign free = !busy_q || (!result_stall && last);

	// advance through the results, one per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= 4'd0;
		end else if (verdict.valid && free) begin
			busy_q <= 1'b1;
			k_q    <= 4'd0;
		end else if (busy_q && !result_stall) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q + 4'd1;
			end
		end
	end

	// hold a copy of the words so the next frame can overwrite the store
	always_ff @(posedge clk) begin
		if (verdict.valid && free) begin
			status_q <= verdict.status;
			snap_q   <= verdict.words;
		end
	end

	assign result_valid         = busy_q;
	assign result.frame_status  = status_q;
	assign result.channel_index = is_error ? 4'd0 : k_q;
	assign result.channel_value = is_error ? 16'd0 : snap_q[k_q];
	assign result.last_result   = last;

endmodule

// File: rtl/core/ibus_frame_decoder.sv
// Decoder for the 32-byte 14-channel serial radio-control receiver frame. Each item is one
// received byte;
// start_of_frame forces it to be byte 0, and after byte 31 the position wraps on its own.
// Bytes pass through an input register and are absorbed at one per cycle. When byte 31
// arrives the frame is judged: a bad header (status 1, reported ahead of a bad checksum)
// or a bad checksum (status 2) gives one error result, a good frame gives the channel
// results in order, one per cycle unless result_stall is high, the last one marked.
// Byte 31 waits in the input register while the results of the previous frame are
// still being delivered, so input is held up only when the result side stalls.
module ibus_frame_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  ibfd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output ibfd_pkg::result_t result
);

	logic                 valid_s1;
	ibfd_pkg::item_t      item_s1;
	logic [4:0]           pos_q;
	logic [15:0]          sum_q;
	logic                 header_good_q;
	logic [7:0]           low_byte_q;
	logic [7:0]           cks_low_q;
	ibfd_pkg::words_t     store_q;

	logic [4:0]           p;
	logic [7:0]           b;
	logic                 is_verdict;
	logic                 burst_free;
	logic                 advance;
	logic [15:0]          received;
	logic [3:0]           word_idx;
	ibfd_pkg::verdict_t   verdict;

	assign b          = item_s1.rx_byte;
	assign p          = item_s1.start_of_frame ? ibfd_pkg::POS_HDR0 : pos_q;
	assign is_verdict = (p == ibfd_pkg::POS_CKS1);
	assign advance    = valid_s1 && (!is_verdict || burst_free);
	assign item_stall = valid_s1 && !advance;
	assign word_idx   = p[4:1] - 4'd1;
	assign received   = {b, cks_low_q};

	// hold the input byte until it is absorbed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			item_s1 <= item;
		end
	end

	// track position, sum, header and checksum low byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= 5'd0;
			sum_q         <= 16'd0;
			header_good_q <= 1'b1;
			low_byte_q    <= 8'd0;
			cks_low_q     <= 8'd0;
		end else if (advance) begin
			pos_q <= p + 5'd1;
			if (p == ibfd_pkg::POS_HDR0) begin
				sum_q         <= {8'd0, b};
				header_good_q <= (b == ibfd_pkg::HDR0);
			end else if (p < ibfd_pkg::POS_CKS0) begin
				sum_q <= sum_q + {8'd0, b};
				if (p == ibfd_pkg::POS_HDR1) begin
					header_good_q <= header_good_q && (b == ibfd_pkg::HDR1);
				end else if (!p[0]) begin
					low_byte_q <= b;
				end
			end else if (p == ibfd_pkg::POS_CKS0) begin
				cks_low_q <= b;
			end
		end
	end

	// write the assembled channel word on its high byte
	always_ff @(posedge clk) begin
		if (advance && p[0] && p > ibfd_pkg::POS_HDR1 && p < ibfd_pkg::POS_CKS0) begin
			store_q[word_idx] <= {b, low_byte_q};
		end
	end

	// judge the frame on its last byte
	always_comb begin
		verdict.valid = valid_s1 && is_verdict;
		verdict.words = store_q;
		priority if (!header_good_q) begin
			verdict.status = ibfd_pkg::STATUS_HEADER;
		end else if (received != (ibfd_pkg::SUM_BASE - sum_q)) begin
			verdict.status = ibfd_pkg::STATUS_CHECKSUM;
		end else begin
			verdict.status = ibfd_pkg::STATUS_OK;
		end
	end

	ibfd_burst u_burst (
		.clk          (clk),
		.arst_n       (arst_n),
		.verdict      (verdict),
		.free         (burst_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
